// ===== sv/lc2k_processor_step_unit_macros.svh =====
// Assertion macros for the LC-2K step unit.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef LC2K_PROCESSOR_STEP_UNIT_MACROS_SVH
`define LC2K_PROCESSOR_STEP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LC2K_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LC2K_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define LC2K_ASSERT(name, clk, rst, prop, msg)
`define LC2K_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

// ===== sv/lc2k_pkg.sv =====
// Shared types, codes and constants of the LC-2K step unit.
// No dependencies; used by every other module of the block.
`timescale 1ns / 1ps

package lc2k_pkg;

   localparam int unsigned MEM_WORDS_DEFAULT = 65536;
   localparam int unsigned REG_COUNT         = 8;
   localparam int unsigned WORD_W            = 32;
   localparam int unsigned REG_IDX_W         = 3;
   localparam int unsigned PC_W              = 16;
   localparam int unsigned ADDR_IN_W         = 16;
   localparam int unsigned FUNC_W            = 2;
   localparam int unsigned OPCODE_W          = 3;
   localparam int unsigned OFFSET_W          = 16;
   localparam int unsigned OPCODE_LSB        = 22;
   localparam int unsigned REGA_LSB          = 19;
   localparam int unsigned REGB_LSB          = 16;
   localparam int unsigned DEST_LSB          = 0;
   localparam logic [WORD_W-1:0] COUNT_MAX   = '1;

   typedef enum logic [FUNC_W-1:0] {
      FN_MEM_WRITE = 2'd0,
      FN_EXECUTE   = 2'd1,
      FN_MEM_READ  = 2'd2,
      FN_REG_READ  = 2'd3
   } func_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD  = 3'd0,
      OP_NOR  = 3'd1,
      OP_LW   = 3'd2,
      OP_SW   = 3'd3,
      OP_BEQ  = 3'd4,
      OP_JALR = 3'd5,
      OP_HALT = 3'd6,
      OP_NOOP = 3'd7
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WR_MOD,
      ST_RD_MOD,
      ST_MEM_CAPT,
      ST_REG_CAPT,
      ST_DECODE,
      ST_READ_A,
      ST_READ_B,
      ST_EXECUTE,
      ST_LW_MOD,
      ST_LW_WB,
      ST_SW_MOD,
      ST_PC_MOD,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MOD_ADDR,
      MOD_EA,
      MOD_BRANCH,
      MOD_JALR
   } mod_sel_type;

   typedef enum logic [1:0] {
      RRD_REGA,
      RRD_REGB,
      RRD_INDEX
   } reg_rsel_type;

   typedef enum logic [1:0] {
      RWR_ALU,
      RWR_LINK,
      RWR_LOAD
   } reg_wsel_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [ADDR_IN_W-1:0] address;
      logic [REG_IDX_W-1:0] reg_index;
      logic signed [WORD_W-1:0] data;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] read_data;
      logic [PC_W-1:0]          pc;
      logic                     halted;
      logic                     executed;
      logic [WORD_W-1:0]        instr_count;
   } rsp_type;

   typedef struct packed {
      logic         capture_req;
      logic         mod_start;
      mod_sel_type  mod_sel;
      logic         mem_we;
      logic         mem_wr_b;
      logic         mem_re;
      logic         mem_rd_mod;
      logic         instr_load;
      logic         reg_re;
      reg_rsel_type reg_rsel;
      logic         a_load;
      logic         b_load;
      logic         reg_we;
      reg_wsel_type reg_wsel;
      logic         pc_inc;
      logic         pc_mod;
      logic         halt_set;
      logic         retire;
      logic         rdat_mem;
      logic         rdat_reg;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      func_type   func;
      logic       halted;
      opcode_type opcode;
      logic       a_eq_b;
      logic       mod_busy;
      logic       rsp_free;
   } status_type;

   function automatic logic [WORD_W-1:0] sign_extend_offset(input logic [OFFSET_W-1:0] off);
      return {{(WORD_W - OFFSET_W){off[OFFSET_W-1]}}, off};
   endfunction

endpackage

// ===== sv/lc2k_processor_step_unit.sv =====
// Top level of the LC-2K step unit: one beat writes or reads memory, reads a register
// or executes one instruction. Depends on lc2k_pkg, lc2k_ctrl and lc2k_dpath.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  lc2k_pkg::req_type
//   rsp_      out        rsp_valid / rsp_ready  lc2k_pkg::rsp_type
//
// One beat is in flight at a time; its steps are sequenced around the single read port
// of the word memory and of the register file.
// When MEM_WORDS is not a power of two, each address or jump reduction waits on the
// remainder unit.
// Reset clears the program counter, halt flag, count and register file; memory is not cleared.
// A stalled result waits in the output register; the next beat is taken once it is loaded.
`timescale 1ns / 1ps

module lc2k_processor_step_unit #(
   parameter int unsigned MEM_WORDS = lc2k_pkg::MEM_WORDS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lc2k_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lc2k_pkg::rsp_type rsp_payload
);
   import lc2k_pkg::*;

   cmd_type    cmd;
   status_type status;

   lc2k_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lc2k_dpath #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sv/lc2k_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on lc2k_pkg for default sizes only.
`timescale 1ns / 1ps

module lc2k_ram #(
   parameter int unsigned WIDTH = lc2k_pkg::WORD_W,
   parameter int unsigned DEPTH = lc2k_pkg::MEM_WORDS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/lc2k_dpath.sv =====
// Datapath of the LC-2K step unit: word memory, register file, modulo unit and result register.
// Depends on lc2k_pkg, lc2k_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "lc2k_processor_step_unit_macros.svh"

module lc2k_dpath #(
   parameter int unsigned MEM_WORDS = lc2k_pkg::MEM_WORDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lc2k_pkg::req_type    req_payload,
   input  lc2k_pkg::cmd_type    cmd,
   output lc2k_pkg::status_type status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output lc2k_pkg::rsp_type    rsp_payload
);
   import lc2k_pkg::*;

   localparam int unsigned AW        = $clog2(MEM_WORDS);
   localparam logic [AW:0] MEM_LIMIT = (AW + 1)'(MEM_WORDS);
   localparam bit          MEM_POW2  = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
   localparam int unsigned MOD_CNT_W = 2;
   localparam int unsigned PROD_W    = 2 * WORD_W;
   localparam logic [MOD_CNT_W-1:0] MOD_STEPS = MOD_CNT_W'(3);
   localparam logic [WORD_W-1:0]    MOD_RECIP =
      WORD_W'((PROD_W'(1) << WORD_W) / PROD_W'(MEM_WORDS));

   req_type                 req_ff;
   logic [WORD_W-1:0]       instr_ff;
   logic [WORD_W-1:0]       a_ff;
   logic [WORD_W-1:0]       b_ff;
   logic [AW-1:0]           pc_ff;
   logic [AW-1:0]           pc_in;
   logic                    halted_ff;
   logic [WORD_W-1:0]       count_ff;
   logic                    executed_ff;
   logic [WORD_W-1:0]       rdat_ff;
   logic [REG_COUNT-1:0]    reg_valid_ff;
   logic                    reg_rvalid_ff;
   logic                    mod_busy_ff;
   logic [MOD_CNT_W-1:0]    mod_cnt_ff;
   logic [WORD_W-1:0]       mod_val_ff;
   logic [PROD_W-1:0]       mod_prod_ff;
   logic [AW:0]             mod_est_ff;
   logic [AW:0]             mod_est_in;
   logic [AW-1:0]           mod_rem_ff;
   logic [AW-1:0]           mod_rem_in;
   logic [WORD_W-1:0]       mod_quot;
   logic [WORD_W-1:0]       mod_back;
   logic [WORD_W-1:0]       mod_operand;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic [WORD_W-1:0]       mem_rdata;
   logic [WORD_W-1:0]       mem_wdata;
   logic [AW-1:0]           mem_raddr;
   logic [WORD_W-1:0]       reg_rdata;
   logic [WORD_W-1:0]       reg_word;
   logic [REG_IDX_W-1:0]    reg_raddr;
   logic [REG_IDX_W-1:0]    reg_waddr;
   logic [WORD_W-1:0]       reg_wdata;

   logic [REG_IDX_W-1:0]    instr_rega;
   logic [REG_IDX_W-1:0]    instr_regb;
   logic [REG_IDX_W-1:0]    instr_dest;
   opcode_type              opcode;
   logic [WORD_W-1:0]       offset;
   logic [AW:0]             pc_plus1;
   logic [WORD_W-1:0]       link;
   logic [WORD_W-1:0]       alu_result;
   logic                    rsp_free;

   assign instr_rega = instr_ff[REGA_LSB +: REG_IDX_W];
   assign instr_regb = instr_ff[REGB_LSB +: REG_IDX_W];
   assign instr_dest = instr_ff[DEST_LSB +: REG_IDX_W];
   assign opcode     = opcode_type'(instr_ff[OPCODE_LSB +: OPCODE_W]);
   assign offset     = sign_extend_offset(instr_ff[OFFSET_W-1:0]);
   assign pc_plus1   = (AW + 1)'(pc_ff) + (AW + 1)'(1);
   assign link       = WORD_W'(pc_plus1);
   assign reg_word   = reg_rvalid_ff ? reg_rdata : '0;
   assign alu_result = (opcode == OP_NOR) ? ~(a_ff | b_ff) : a_ff + b_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // Request capture and operand registers.
   always_ff @(posedge clock) begin
      if (cmd.capture_req) begin
         req_ff <= req_payload;
      end
      if (cmd.instr_load) begin
         instr_ff <= mem_rdata;
      end
      if (cmd.a_load) begin
         a_ff <= reg_word;
      end
      if (cmd.b_load) begin
         b_ff <= reg_word;
      end
      if (cmd.reg_re) begin
         reg_rvalid_ff <= reg_valid_ff[reg_raddr];
      end
   end

   // Remainder unit: a mask when the memory size is a power of two, otherwise a
   // reciprocal estimate of the quotient, a multiply back and one corrective
   // subtraction, one step per cycle.
   always_comb begin
      unique case (cmd.mod_sel)
         MOD_ADDR:   mod_operand = WORD_W'(req_ff.address);
         MOD_EA:     mod_operand = a_ff + offset;
         MOD_BRANCH: mod_operand = link + offset;
         MOD_JALR:   mod_operand = (instr_rega == instr_regb) ? link : a_ff;
         default:    mod_operand = a_ff;
      endcase
   end

   assign mod_quot   = mod_prod_ff[PROD_W-1:WORD_W];
   assign mod_back   = mod_quot * WORD_W'(MEM_WORDS);
   assign mod_est_in = (AW + 1)'(mod_val_ff - mod_back);
   assign mod_rem_in = (mod_est_ff >= MEM_LIMIT) ? AW'(mod_est_ff - MEM_LIMIT) : mod_est_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_busy_ff <= 1'b0;
      end else if (cmd.mod_start) begin
         mod_busy_ff <= !MEM_POW2;
      end else if (mod_busy_ff) begin
         mod_busy_ff <= (mod_cnt_ff != MOD_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mod_start) begin
         mod_val_ff <= mod_operand;
         mod_cnt_ff <= MOD_STEPS;
         mod_rem_ff <= MEM_POW2 ? mod_operand[AW-1:0] : '0;
      end else if (mod_busy_ff) begin
         mod_cnt_ff  <= mod_cnt_ff - MOD_CNT_W'(1);
         mod_prod_ff <= PROD_W'(mod_val_ff) * PROD_W'(MOD_RECIP);
         mod_est_ff  <= mod_est_in;
         mod_rem_ff  <= mod_rem_in;
      end
   end

   // Word memory.
   assign mem_wdata = cmd.mem_wr_b ? b_ff : req_ff.data;
   assign mem_raddr = cmd.mem_rd_mod ? mod_rem_ff : pc_ff;

   lc2k_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_word_mem (
      .clock (clock),
      .we    (cmd.mem_we),
      .waddr (mod_rem_ff),
      .wdata (mem_wdata),
      .re    (cmd.mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Register file; a register never written reads as zero.
   always_comb begin
      unique case (cmd.reg_rsel)
         RRD_REGA:  reg_raddr = mem_rdata[REGA_LSB +: REG_IDX_W];
         RRD_REGB:  reg_raddr = instr_regb;
         RRD_INDEX: reg_raddr = req_ff.reg_index;
         default:   reg_raddr = req_ff.reg_index;
      endcase
   end

   always_comb begin
      unique case (cmd.reg_wsel)
         RWR_ALU: begin
            reg_waddr = instr_dest;
            reg_wdata = alu_result;
         end
         RWR_LINK: begin
            reg_waddr = instr_regb;
            reg_wdata = link;
         end
         RWR_LOAD: begin
            reg_waddr = instr_regb;
            reg_wdata = mem_rdata;
         end
         default: begin
            reg_waddr = instr_dest;
            reg_wdata = alu_result;
         end
      endcase
   end

   lc2k_ram #(
      .WIDTH (WORD_W),
      .DEPTH (REG_COUNT)
   ) u_reg_file (
      .clock (clock),
      .we    (cmd.reg_we),
      .waddr (reg_waddr),
      .wdata (reg_wdata),
      .re    (cmd.reg_re),
      .raddr (reg_raddr),
      .rdata (reg_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_valid_ff <= '0;
      end else if (cmd.reg_we) begin
         reg_valid_ff[reg_waddr] <= 1'b1;
      end
   end

   // Architectural state.
   always_comb begin
      pc_in = pc_ff;
      priority if (cmd.pc_mod) begin
         pc_in = mod_rem_ff;
      end else if (cmd.pc_inc) begin
         pc_in = (pc_plus1 == MEM_LIMIT) ? '0 : pc_plus1[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         halted_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         pc_ff <= pc_in;
         if (cmd.halt_set) begin
            halted_ff <= 1'b1;
         end
         if (cmd.retire && (count_ff != COUNT_MAX)) begin
            count_ff <= count_ff + WORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_req) begin
         executed_ff <= 1'b0;
         rdat_ff     <= '0;
      end else begin
         if (cmd.retire) begin
            executed_ff <= 1'b1;
         end
         if (cmd.rdat_mem) begin
            rdat_ff <= mem_rdata;
         end else if (cmd.rdat_reg) begin
            rdat_ff <= reg_word;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.read_data   <= rdat_ff;
         rsp_ff.pc          <= PC_W'(pc_ff);
         rsp_ff.halted      <= halted_ff;
         rsp_ff.executed    <= executed_ff;
         rsp_ff.instr_count <= count_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign status.func     = func_type'(req_ff.func);
   assign status.halted   = halted_ff;
   assign status.opcode   = opcode;
   assign status.a_eq_b   = (a_ff == b_ff);
   assign status.mod_busy = mod_busy_ff;
   assign status.rsp_free = rsp_free;

   `LC2K_ASSERT(a_mod_no_restart, clock, reset, !(cmd.mod_start && mod_busy_ff), "Remainder unit restarted while busy.")
   `LC2K_ASSERT(a_mem_one_access, clock, reset, !(cmd.mem_we && cmd.mem_re), "Word memory read and written in one cycle.")
   `LC2K_ASSERT(a_pc_in_range, clock, reset, (AW + 1)'(pc_ff) < MEM_LIMIT, "Program counter beyond memory size.")
   `LC2K_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff, "Halt flag cleared.")
   `LC2K_ASSERT(a_rsp_no_overwrite, clock, reset, !(cmd.rsp_load && rsp_valid_ff && !rsp_ready), "Result overwritten before it was taken.")

endmodule

// ===== sv/lc2k_ctrl.sv =====
// Controller state machine of the LC-2K step unit: sequences each beat through the datapath.
// Depends on lc2k_pkg.
`timescale 1ns / 1ps

module lc2k_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lc2k_pkg::status_type status,
   output lc2k_pkg::cmd_type    cmd
);
   import lc2k_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.func)
               FN_MEM_WRITE: state_in = ST_WR_MOD;
               FN_EXECUTE:   state_in = status.halted ? ST_DONE : ST_DECODE;
               FN_MEM_READ:  state_in = ST_RD_MOD;
               FN_REG_READ:  state_in = ST_REG_CAPT;
               default:      state_in = ST_DONE;
            endcase
         end
         ST_WR_MOD: begin
            if (!status.mod_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_RD_MOD: begin
            if (!status.mod_busy) begin
               state_in = ST_MEM_CAPT;
            end
         end
         ST_MEM_CAPT: state_in = ST_DONE;
         ST_REG_CAPT: state_in = ST_DONE;
         ST_DECODE:   state_in = ST_READ_A;
         ST_READ_A:   state_in = ST_READ_B;
         ST_READ_B:   state_in = ST_EXECUTE;
         ST_EXECUTE: begin
            unique case (status.opcode)
               OP_LW:   state_in = ST_LW_MOD;
               OP_SW:   state_in = ST_SW_MOD;
               OP_BEQ:  state_in = status.a_eq_b ? ST_PC_MOD : ST_DONE;
               OP_JALR: state_in = ST_PC_MOD;
               default: state_in = ST_DONE;
            endcase
         end
         ST_LW_MOD: begin
            if (!status.mod_busy) begin
               state_in = ST_LW_WB;
            end
         end
         ST_LW_WB: state_in = ST_DONE;
         ST_SW_MOD: begin
            if (!status.mod_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_PC_MOD: begin
            if (!status.mod_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture_req = req_valid;
         end
         ST_DISPATCH: begin
            unique case (status.func)
               FN_MEM_WRITE, FN_MEM_READ: begin
                  cmd.mod_start = 1'b1;
                  cmd.mod_sel   = MOD_ADDR;
               end
               FN_EXECUTE: begin
                  cmd.mem_re = !status.halted;
               end
               FN_REG_READ: begin
                  cmd.reg_re   = 1'b1;
                  cmd.reg_rsel = RRD_INDEX;
               end
               default: begin
                  cmd.mem_re = 1'b0;
               end
            endcase
         end
         ST_WR_MOD: begin
            cmd.mem_we = !status.mod_busy;
         end
         ST_RD_MOD: begin
            cmd.mem_re     = !status.mod_busy;
            cmd.mem_rd_mod = 1'b1;
         end
         ST_MEM_CAPT: begin
            cmd.rdat_mem = 1'b1;
         end
         ST_REG_CAPT: begin
            cmd.rdat_reg = 1'b1;
         end
         ST_DECODE: begin
            cmd.instr_load = 1'b1;
            cmd.reg_re     = 1'b1;
            cmd.reg_rsel   = RRD_REGA;
         end
         ST_READ_A: begin
            cmd.a_load   = 1'b1;
            cmd.reg_re   = 1'b1;
            cmd.reg_rsel = RRD_REGB;
         end
         ST_READ_B: begin
            cmd.b_load = 1'b1;
         end
         ST_EXECUTE: begin
            unique case (status.opcode)
               OP_ADD, OP_NOR: begin
                  cmd.reg_we   = 1'b1;
                  cmd.reg_wsel = RWR_ALU;
                  cmd.pc_inc   = 1'b1;
                  cmd.retire   = 1'b1;
               end
               OP_LW, OP_SW: begin
                  cmd.mod_start = 1'b1;
                  cmd.mod_sel   = MOD_EA;
               end
               OP_BEQ: begin
                  cmd.mod_start = status.a_eq_b;
                  cmd.mod_sel   = MOD_BRANCH;
                  cmd.pc_inc    = !status.a_eq_b;
                  cmd.retire    = !status.a_eq_b;
               end
               OP_JALR: begin
                  cmd.reg_we    = 1'b1;
                  cmd.reg_wsel  = RWR_LINK;
                  cmd.mod_start = 1'b1;
                  cmd.mod_sel   = MOD_JALR;
               end
               OP_HALT: begin
                  cmd.halt_set = 1'b1;
                  cmd.pc_inc   = 1'b1;
                  cmd.retire   = 1'b1;
               end
               OP_NOOP: begin
                  cmd.pc_inc = 1'b1;
                  cmd.retire = 1'b1;
               end
               default: begin
                  cmd.pc_inc = 1'b1;
                  cmd.retire = 1'b1;
               end
            endcase
         end
         ST_LW_MOD: begin
            cmd.mem_re     = !status.mod_busy;
            cmd.mem_rd_mod = 1'b1;
         end
         ST_LW_WB: begin
            cmd.reg_we   = 1'b1;
            cmd.reg_wsel = RWR_LOAD;
            cmd.pc_inc   = 1'b1;
            cmd.retire   = 1'b1;
         end
         ST_SW_MOD: begin
            cmd.mem_we   = !status.mod_busy;
            cmd.mem_wr_b = 1'b1;
            cmd.pc_inc   = !status.mod_busy;
            cmd.retire   = !status.mod_busy;
         end
         ST_PC_MOD: begin
            cmd.pc_mod = !status.mod_busy;
            cmd.retire = !status.mod_busy;
         end
         ST_DONE: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd.rsp_load = 1'b0;
         end
      endcase
   end

endmodule
